@@ hdl/etc_pkg.sv @@
package etc_pkg;

  localparam int unsigned NOW_W   = 64;
  localparam int unsigned RANK_W  = 8;
  localparam int unsigned OP_W    = 4;
  localparam int unsigned CFG_W   = 5;

  localparam int unsigned MAX_WIDTH_DEF = 16;
  localparam logic [CFG_W-1:0] MESH_WIDTH_RST = 5'd4;

  // Pipeline layout: input register, eight remainder digits, offset sum, output.
  localparam int unsigned NSTG      = 11;
  localparam int unsigned DIGIT_W   = 8;
  localparam int unsigned REM_STG   = NOW_W / DIGIT_W;
  localparam int unsigned STG_RING  = 3;
  localparam int unsigned STG_SUM   = REM_STG + 1;
  localparam int unsigned STG_OUT   = REM_STG + 2;

  localparam logic [OP_W-1:0] OP_SEND_REMOVE    = 4'd0;
  localparam logic [OP_W-1:0] OP_SEND_DECREMENT = 4'd1;
  localparam logic [OP_W-1:0] OP_RECV_INSERT    = 4'd2;
  localparam logic [OP_W-1:0] OP_RECV_INCREMENT = 4'd3;
  localparam logic [OP_W-1:0] OP_READY_RECV     = 4'd4;
  localparam logic [OP_W-1:0] OP_READY_COMMIT   = 4'd5;
  localparam logic [OP_W-1:0] OP_READY_RELEASE  = 4'd6;
  localparam logic [OP_W-1:0] OP_BARRIER_SET    = 4'd7;
  localparam logic [OP_W-1:0] OP_BARRIER_ENABLE = 4'd8;
  localparam logic [OP_W-1:0] OP_BARRIER_CLEAR  = 4'd9;

  typedef struct packed {
    logic [NSTG-1:0] en;
    logic [NSTG-1:0] vld;
  } pipe_ctl_t;

endpackage

@@ hdl/etc_ctrl.sv @@
module etc_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               out_ready_i,
  output logic               in_ready_o,
  output etc_pkg::pipe_ctl_t ctl_o
);

  localparam int unsigned N = etc_pkg::NSTG;

  logic [N-1:0] vld_q, vld_d;
  logic [N-1:0] rdy;

  // A stage loads when it is empty or its content moves on this cycle.
  always_comb begin
    rdy[N-1] = !vld_q[N-1] || out_ready_i;
    for (int k = N - 2; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
  end

  always_comb begin
    vld_d[0] = rdy[0] ? in_valid_i : vld_q[0];
    for (int k = 1; k < N; k++) begin
      vld_d[k] = rdy[k] ? vld_q[k-1] : vld_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign in_ready_o = rdy[0];
  assign ctl_o.en   = rdy;
  assign ctl_o.vld  = vld_q;

endmodule

@@ hdl/etc_rem_pipe.sv @@
module etc_rem_pipe #(
  parameter int unsigned DW = 5
) (
  input  logic                        clk_i,
  input  logic [etc_pkg::NSTG-1:0]    en_i,
  input  logic [etc_pkg::NOW_W-1:0]   dividend_i,
  input  logic [DW-1:0]               divisor_i,
  output logic [DW-1:0]               rem_o
);

  localparam int unsigned NS = etc_pkg::REM_STG;
  localparam int unsigned DG = etc_pkg::DIGIT_W;
  localparam int unsigned NW = etc_pkg::NOW_W;

  logic [DW-1:0] rem_q [1:NS];
  logic [NW-1:0] lo_q  [1:NS-1];

  for (genvar g = 1; g <= NS; g++) begin : g_stg
    logic [DW-1:0] r_in;
    logic [NW-1:0] src;
    logic [DW-1:0] r_out;

    if (g == 1) begin : g_first
      assign r_in = '0;
      assign src  = dividend_i;
    end else begin : g_next
      assign r_in = rem_q[g-1];
      assign src  = lo_q[g-1];
    end

    // Restoring remainder, one dividend bit per step, top digit first.
    always_comb begin
      logic [DW:0]   t;
      logic [DW-1:0] r;
      r = r_in;
      for (int b = DG - 1; b >= 0; b--) begin
        t = {r, src[NW-DG+b]};
        if (t >= {1'b0, divisor_i}) begin
          t = t - {1'b0, divisor_i};
        end
        r = t[DW-1:0];
      end
      r_out = r;
    end

    always_ff @(posedge clk_i) begin
      if (en_i[g]) begin
        rem_q[g] <= r_out;
      end
    end

    if (g < NS) begin : g_lo
      always_ff @(posedge clk_i) begin
        if (en_i[g]) begin
          lo_q[g] <= src << DG;
        end
      end
    end
  end

  assign rem_o = rem_q[NS];

endmodule

@@ hdl/etc_ring.sv @@
module etc_ring #(
  parameter int unsigned MAX_WIDTH = etc_pkg::MAX_WIDTH_DEF
) (
  input  logic                         clk_i,
  input  logic [etc_pkg::NSTG-1:0]     en_i,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]           w_i,
  input  logic [$clog2(MAX_WIDTH*MAX_WIDTH+1)-1:0] size_i,
  input  logic [etc_pkg::RANK_W-1:0]   src_i,
  input  logic [etc_pkg::RANK_W-1:0]   dst_i,
  output logic [$clog2(MAX_WIDTH*MAX_WIDTH+1)-1:0] dist_o
);

  localparam int unsigned WW  = $clog2(MAX_WIDTH + 1);
  localparam int unsigned SZW = $clog2(MAX_WIDTH * MAX_WIDTH + 1);
  localparam int unsigned RKW = etc_pkg::RANK_W;
  localparam int unsigned NW  = (SZW > RKW) ? SZW : RKW;

  logic [RKW-1:0] rk_in [2];
  logic [WW-1:0]  col_d [2];
  logic           odd_d [2];
  logic [RKW-1:0] rk_q  [2];
  logic [WW-1:0]  col_q [2];
  logic           odd_q [2];
  logic [SZW-1:0] snake [2];
  logic [SZW-1:0] r_d, r_q;
  logic [SZW-1:0] dist_d, dist_q;

  assign rk_in[0] = src_i;
  assign rk_in[1] = dst_i;

  // Split each rank into row parity and column by restoring division.
  always_comb begin
    logic [WW:0]   t;
    logic [WW-1:0] r;
    logic          q;
    for (int j = 0; j < 2; j++) begin
      r = '0;
      q = 1'b0;
      for (int b = RKW - 1; b >= 0; b--) begin
        t = {r, rk_in[j][b]};
        q = (t >= {1'b0, w_i});
        if (q) begin
          t = t - {1'b0, w_i};
        end
        r = t[WW-1:0];
      end
      col_d[j] = r;
      odd_d[j] = q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      for (int j = 0; j < 2; j++) begin
        rk_q[j]  <= rk_in[j];
        col_q[j] <= col_d[j];
        odd_q[j] <= odd_d[j];
      end
    end
  end

  // Odd rows run right to left on the ring.
  always_comb begin
    logic [NW:0]  s;
    logic [SZW:0] t;
    for (int j = 0; j < 2; j++) begin
      if (odd_q[j]) begin
        s = (NW+1)'(rk_q[j]) + (NW+1)'(w_i) - (NW+1)'({col_q[j], 1'b0}) - (NW+1)'(1);
      end else begin
        s = (NW+1)'(rk_q[j]);
      end
      snake[j] = s[SZW-1:0];
    end
    t = (SZW+1)'(snake[1]) + (SZW+1)'(size_i) - (SZW+1)'(snake[0]);
    if (t >= (SZW+1)'(size_i)) begin
      t = t - (SZW+1)'(size_i);
    end
    r_d = t[SZW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      r_q <= r_d;
    end
  end

  always_comb begin
    logic [SZW-1:0] other;
    other  = size_i - r_q;
    dist_d = (r_q < other) ? r_q : other;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[etc_pkg::STG_RING]) begin
      dist_q <= dist_d;
    end
  end

  assign dist_o = dist_q;

endmodule

@@ hdl/noc_event_time_calculator_unit.sv @@
// Network event completion-time calculator.
// Input channel: in_valid_i / in_ready_o with operation_i, now_cycle_i,
// source_rank_i, target_rank_i and late_flag_i. Output channel:
// out_valid_o / out_ready_i with event_cycle_o and bad_request_o, one result
// beat per input beat, in order. The mesh width register is written through
// mesh_width_we_i / mesh_width_i; the user must do so only while no beat is
// in flight, which the block does not enforce. It resets to 4 and is clamped
// to 2..MAX_WIDTH. One beat per cycle is accepted unless the receiver stalls.
// Eight of the stages form the remainder pipelines (now mod W and now mod
// W*W/2, eight dividend bits per stage); the ring distance runs alongside
// them, then one stage sums the offsets and one does the 64-bit add. Reset
// empties the pipeline and drops anything in flight. When the receiver
// stalls, results hold in the output register and the stages behind it keep
// filling; in_ready_o falls only once every stage holds a beat.
module noc_event_time_calculator_unit #(
  parameter int unsigned MAX_WIDTH = etc_pkg::MAX_WIDTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        mesh_width_we_i,
  input  logic [etc_pkg::CFG_W-1:0]   mesh_width_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [etc_pkg::OP_W-1:0]    operation_i,
  input  logic [etc_pkg::NOW_W-1:0]   now_cycle_i,
  input  logic [etc_pkg::RANK_W-1:0]  source_rank_i,
  input  logic [etc_pkg::RANK_W-1:0]  target_rank_i,
  input  logic                        late_flag_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [etc_pkg::NOW_W-1:0]   event_cycle_o,
  output logic                        bad_request_o
);

  localparam int unsigned WW  = $clog2(MAX_WIDTH + 1);
  localparam int unsigned SZW = $clog2(MAX_WIDTH * MAX_WIDTH + 1);
  localparam int unsigned PW  = $clog2(MAX_WIDTH * MAX_WIDTH / 2 + 1);
  localparam int unsigned SMW = SZW + 2;
  localparam int unsigned NW  = etc_pkg::NOW_W;
  localparam int unsigned NS  = etc_pkg::REM_STG;
  localparam int unsigned SUM = etc_pkg::STG_SUM;

  logic [etc_pkg::CFG_W-1:0] mesh_width_q;
  logic [WW-1:0]  w_eff;
  logic [SZW-1:0] size;
  logic [PW-1:0]  flit;

  etc_pkg::pipe_ctl_t ctl;

  logic [NW-1:0]              now_q  [0:SUM];
  logic [etc_pkg::OP_W-1:0]   op_q   [0:NS];
  logic                       late_q [0:NS];
  logic                       bad_q  [1:SUM];
  logic [etc_pkg::RANK_W-1:0] src_q, dst_q;
  logic [SZW-1:0]             ring_dist;
  logic [SZW-1:0]             dist_q [etc_pkg::STG_RING+1:NS];
  logic [WW-1:0]              rem_w;
  logic [PW-1:0]              rem_p;
  logic                       bad_d;
  logic [SMW-1:0]             small_d, small_q;
  logic [NW-1:0]              event_cycle_q;
  logic                       bad_request_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mesh_width_q <= etc_pkg::MESH_WIDTH_RST;
    end else if (mesh_width_we_i) begin
      mesh_width_q <= mesh_width_i;
    end
  end

  // Clamp the width; size and flit period follow from it.
  always_comb begin
    if (32'(mesh_width_q) < 32'd2) begin
      w_eff = WW'(2);
    end else if (32'(mesh_width_q) > 32'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(mesh_width_q);
    end
    size = SZW'(w_eff) * SZW'(w_eff);
    flit = PW'(size >> 1);
  end

  etc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .out_ready_i (out_ready_i),
    .in_ready_o  (in_ready_o),
    .ctl_o       (ctl)
  );

  always_ff @(posedge clk_i) begin
    if (ctl.en[0]) begin
      now_q[0]  <= now_cycle_i;
      op_q[0]   <= operation_i;
      late_q[0] <= late_flag_i;
      src_q     <= source_rank_i;
      dst_q     <= target_rank_i;
    end
    for (int k = 1; k <= SUM; k++) begin
      if (ctl.en[k]) begin
        now_q[k] <= now_q[k-1];
      end
    end
    for (int k = 1; k <= NS; k++) begin
      if (ctl.en[k]) begin
        op_q[k]   <= op_q[k-1];
        late_q[k] <= late_q[k-1];
      end
    end
    if (ctl.en[1]) begin
      bad_q[1] <= bad_d;
    end
    for (int k = 2; k <= SUM; k++) begin
      if (ctl.en[k]) begin
        bad_q[k] <= bad_q[k-1];
      end
    end
    if (ctl.en[etc_pkg::STG_RING+1]) begin
      dist_q[etc_pkg::STG_RING+1] <= ring_dist;
    end
    for (int k = etc_pkg::STG_RING + 2; k <= NS; k++) begin
      if (ctl.en[k]) begin
        dist_q[k] <= dist_q[k-1];
      end
    end
  end

  assign bad_d = (SZW'(src_q) >= size) || (SZW'(dst_q) >= size)
              || (op_q[0] > etc_pkg::OP_BARRIER_CLEAR)
              || (32'(src_q) >= 32'(size)) || (32'(dst_q) >= 32'(size));

  etc_rem_pipe #(.DW(WW)) u_rem_w (
    .clk_i      (clk_i),
    .en_i       (ctl.en),
    .dividend_i (now_q[0]),
    .divisor_i  (w_eff),
    .rem_o      (rem_w)
  );

  etc_rem_pipe #(.DW(PW)) u_rem_p (
    .clk_i      (clk_i),
    .en_i       (ctl.en),
    .dividend_i (now_q[0]),
    .divisor_i  (flit),
    .rem_o      (rem_p)
  );

  etc_ring #(.MAX_WIDTH(MAX_WIDTH)) u_ring (
    .clk_i  (clk_i),
    .en_i   (ctl.en),
    .w_i    (w_eff),
    .size_i (size),
    .src_i  (src_q),
    .dst_i  (dst_q),
    .dist_o (ring_dist)
  );

  // Offset past now, kept narrow; the wide add follows in the next stage.
  always_comb begin
    logic [SMW-1:0] send_off;
    logic [SMW-1:0] flit_off;
    logic [SMW-1:0] flit_late;
    logic [SMW-1:0] flit_ext;
    logic [SMW-1:0] dist_ext;
    logic [SMW-1:0] w_ext;
    w_ext     = SMW'(w_eff);
    flit_ext  = SMW'(flit);
    dist_ext  = SMW'(dist_q[NS]);
    send_off  = (rem_w == '0 && late_q[NS]) ? '0 : w_ext - SMW'(rem_w);
    flit_off  = flit_ext - SMW'(rem_p);
    flit_late = (rem_p == '0 && late_q[NS]) ? '0 : flit_off;
    unique case (op_q[NS]) inside
      etc_pkg::OP_SEND_REMOVE:    small_d = send_off + SMW'(1);
      etc_pkg::OP_SEND_DECREMENT: small_d = SMW'(1);
      etc_pkg::OP_RECV_INSERT:    small_d = w_ext << 1;
      etc_pkg::OP_RECV_INCREMENT: small_d = (w_ext << 1) - SMW'(2);
      etc_pkg::OP_READY_RECV:     small_d = flit_off + SMW'(1) + dist_ext;
      etc_pkg::OP_READY_COMMIT,
      etc_pkg::OP_READY_RELEASE:  small_d = flit_late + flit_ext + SMW'(1);
      etc_pkg::OP_BARRIER_SET:    small_d = flit_late + dist_ext;
      etc_pkg::OP_BARRIER_ENABLE: small_d = (rem_p == '0) ? '0 : flit_off;
      etc_pkg::OP_BARRIER_CLEAR:  small_d = flit_off;
      default:                    small_d = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctl.en[SUM]) begin
      small_q <= small_d;
    end
    if (ctl.en[etc_pkg::STG_OUT]) begin
      event_cycle_q <= bad_q[SUM] ? '0 : now_q[SUM] + NW'(small_q);
      bad_request_q <= bad_q[SUM];
    end
  end

  assign out_valid_o   = ctl.vld[etc_pkg::STG_OUT];
  assign event_cycle_o = event_cycle_q;
  assign bad_request_o = bad_request_q;

`ifndef SYNTHESIS
  logic in_acc, out_acc;
  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;

  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && bad_request_o |-> event_cycle_o == '0)
    else $error("flagged result carries a nonzero cycle");

  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> &ctl.vld)
    else $error("input stalled while a stage is empty");

  a_occupancy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> $countones(ctl.vld)
             == $past($countones(ctl.vld)) + $past(in_acc) - $past(out_acc))
    else $error("beat lost or duplicated in pipeline");

  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.vld[NS] |-> (rem_w < w_eff) && (rem_p < flit))
    else $error("remainder not below its period");
`endif

endmodule
